/* design/ffpa_pkg.sv */
package ffpa_pkg;

    localparam int MaxEntriesDef = 128;
    localparam int UtilCap = 100;

    // Function codes of an input word.
    localparam logic FUNC_ALLOC = 1'b0;
    localparam logic FUNC_CLEAR = 1'b1;

    // Register indexes on the configuration port.
    localparam logic REG_POOL_BASE = 1'b0;
    localparam logic REG_POOL_WORDS = 1'b1;

    typedef enum logic [3:0] {
        t_IDLE,
        t_RD,
        t_SCAN,
        t_TAIL,
        t_SHIFT_RD,
        t_SHIFT_WR,
        t_COMMIT,
        t_DIV,
        t_DONE
    } t_state;

    // Start and issue of the utilisation divider.
    typedef struct packed {
        logic        start;
        logic [22:0] dividend;
        logic [15:0] divisor;
    } t_div_req;

    typedef struct packed {
        logic       busy;
        logic [6:0] quot;
    } t_div_rsp;

endpackage

/* design/ffpa_div.sv */
module ffpa_div
    import ffpa_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  t_div_req i_req,
    output t_div_rsp o_rsp
);

    // Restoring division, one quotient bit a cycle; quotient saturates at the cap.
    logic [22:0] r_rem, n_rem;
    logic [22:0] r_quo, n_quo;
    logic [22:0] r_dvd, n_dvd;
    logic [15:0] r_dvs, n_dvs;
    logic [4:0]  r_cnt, n_cnt;
    logic        r_busy, n_busy;
    logic [23:0] w_trial;

    always_comb begin
        n_rem  = r_rem;
        n_quo  = r_quo;
        n_dvd  = r_dvd;
        n_dvs  = r_dvs;
        n_cnt  = r_cnt;
        n_busy = r_busy;
        w_trial = {r_rem, r_dvd[22]} - {8'd0, r_dvs};
        if (i_req.start) begin
            n_rem  = '0;
            n_quo  = '0;
            n_dvd  = i_req.dividend;
            n_dvs  = i_req.divisor;
            n_cnt  = 5'd23;
            n_busy = 1'b1;
        end else if (r_busy) begin
            n_dvd = {r_dvd[21:0], 1'b0};
            if (!w_trial[23]) begin
                n_rem = w_trial[22:0];
                n_quo = {r_quo[21:0], 1'b1};
            end else begin
                n_rem = {r_rem[21:0], r_dvd[22]};
                n_quo = {r_quo[21:0], 1'b0};
            end
            n_cnt = r_cnt - 5'd1;
            if (r_cnt == 5'd1) begin
                n_busy = 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_busy <= n_busy;
            r_cnt  <= n_cnt;
        end
        r_rem <= n_rem;
        r_quo <= n_quo;
        r_dvd <= n_dvd;
        r_dvs <= n_dvs;
    end

    assign o_rsp.busy = r_busy | i_req.start;
    assign o_rsp.quot = (r_quo > 23'(UtilCap)) ? 7'(UtilCap) : r_quo[6:0];

endmodule

/* design/first_fit_pool_allocator.sv */
// Channel | Direction | Handshake               | Words
// in      | input     | i_in_valid / o_in_stall  | i_func, i_size_bytes
// out     | output    | o_out_valid / i_out_stall| o_address .. o_entry_count
// cfg     | input     | APB psel/penable/pready  | pool_base, pool_words
// A word scans each gap in turn (t_RD, t_SCAN), moves each later entry up one slot
// (t_SHIFT_RD, t_SHIFT_WR), commits the new extent (t_COMMIT) and then waits on the
// utilisation divider before the result. The single table port sets the scan pace.
// Reset is synchronous, active low; the table holds undefined data until written.
// The input is stalled from acceptance until the result word has been taken.
module first_fit_pool_allocator
    import ffpa_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_stall,
    input  logic        i_func,
    input  logic [17:0] i_size_bytes,
    output logic        o_out_valid,
    input  logic        i_out_stall,
    output logic [31:0] o_address,
    output logic        o_granted,
    output logic [6:0]  o_utilisation_percent,
    output logic        o_pool_empty_error,
    output logic [7:0]  o_entry_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    localparam int IW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;
    localparam int CW = $clog2(MAX_ENTRIES + 1);

    // Configuration registers.
    logic [31:0] r_pool_base;
    logic [15:0] r_pool_words;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_POOL_WORDS) ? {16'd0, r_pool_words} : r_pool_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pool_base  <= '0;
            r_pool_words <= '0;
        end else if (psel && penable && pwrite) begin
            if (paddr[2] == REG_POOL_BASE) begin
                r_pool_base <= pwdata;
            end else begin
                r_pool_words <= pwdata[15:0];
            end
        end
    end

    // Extent table: one write and one registered read per cycle.
    logic [31:0] mem [MAX_ENTRIES];
    logic [31:0] r_rdata;
    logic [IW-1:0] w_raddr;
    logic          w_we;
    logic [IW-1:0] w_waddr;
    logic [31:0]   w_wdata;

    always_ff @(posedge i_clk) begin
        if (w_we) begin
            mem[w_waddr] <= w_wdata;
        end
        r_rdata <= mem[w_raddr];
    end

    t_state r_state, n_state;
    logic [CW-1:0] r_live, n_live;
    logic [15:0]   r_hw, n_hw;
    logic [CW-1:0] r_idx, n_idx;
    logic [16:0]   r_need, n_need;
    logic [16:0]   r_prev_end, n_prev_end;
    logic [16:0]   r_start, n_start;
    logic [31:0]   r_address, n_address;
    logic          r_granted, n_granted;
    logic [6:0]    r_util;
    logic          r_empty;

    t_div_req w_dreq;
    t_div_rsp w_drsp;

    ffpa_div u_div (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (w_dreq),
        .o_rsp  (w_drsp)
    );

    // Gap arithmetic: the shared compare of each scan step.
    logic [16:0] w_ent_start, w_ent_end;
    logic [18:0] w_gap_top, w_gap_len;
    logic        w_fits;

    assign w_ent_start = {1'b0, r_rdata[31:16]};
    assign w_ent_end   = {1'b0, r_rdata[31:16]} + {1'b0, r_rdata[15:0]};

    always_comb begin
        if (r_state == t_TAIL) begin
            w_gap_top = {3'd0, r_pool_words};
        end else if ({1'b0, r_pool_words} < w_ent_start) begin
            w_gap_top = {3'd0, r_pool_words};
        end else begin
            w_gap_top = {2'd0, w_ent_start};
        end
        w_gap_len = w_gap_top - {2'd0, r_prev_end};
        w_fits = !w_gap_len[18] && (w_gap_len >= {2'd0, r_need});
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            t_IDLE: begin
                if (i_in_valid) begin
                    if (i_func == FUNC_CLEAR) begin
                        n_state = t_DIV;
                    end else if (r_live >= CW'(MAX_ENTRIES)) begin
                        n_state = t_DIV;
                    end else if (r_live == '0) begin
                        n_state = t_TAIL;
                    end else begin
                        n_state = t_RD;
                    end
                end
            end
            t_RD:   n_state = t_SCAN;
            t_SCAN: begin
                if (w_fits) begin
                    n_state = (r_live == r_idx) ? t_COMMIT : t_SHIFT_RD;
                end else if (r_idx + CW'(1) >= r_live) begin
                    n_state = t_TAIL;
                end else begin
                    n_state = t_RD;
                end
            end
            t_TAIL:     n_state = w_fits ? t_COMMIT : t_DIV;
            t_SHIFT_RD: n_state = t_SHIFT_WR;
            // Stay in the shift loop until the cursor reaches the insertion slot.
            t_SHIFT_WR: begin
                n_state = ((r_start - 17'd1) != 17'(r_idx)) ? t_SHIFT_RD : t_COMMIT;
            end
            t_COMMIT:   n_state = t_DIV;
            t_DIV:      n_state = w_drsp.busy ? t_DIV : t_DONE;
            t_DONE:     n_state = i_out_stall ? t_DONE : t_IDLE;
            default:    n_state = t_IDLE;
        endcase
    end

    // Datapath controls. r_start holds the shift cursor during the shift.
    always_comb begin
        n_live     = r_live;
        n_hw       = r_hw;
        n_idx      = r_idx;
        n_need     = r_need;
        n_prev_end = r_prev_end;
        n_start    = r_start;
        n_address  = r_address;
        n_granted  = r_granted;
        w_raddr    = r_idx[IW-1:0];
        w_we       = 1'b0;
        w_waddr    = r_idx[IW-1:0];
        w_wdata    = '0;
        w_dreq     = '0;
        case (r_state)
            t_IDLE: begin
                n_idx      = '0;
                n_prev_end = '0;
                n_address  = '0;
                n_granted  = 1'b0;
                n_need     = 17'(({1'b0, i_size_bytes} + 19'd3) >> 2);
                w_raddr    = '0;
                if (i_in_valid && i_func == FUNC_CLEAR) begin
                    n_live = '0;
                    n_hw   = '0;
                end
            end
            t_SCAN: begin
                if (w_fits) begin
                    n_start = 17'(r_live);
                end else begin
                    n_prev_end = w_ent_end;
                    n_idx      = r_idx + CW'(1);
                end
            end
            t_TAIL: begin
                if (w_fits) begin
                    n_idx = r_live;
                end
            end
            t_SHIFT_RD: begin
                w_raddr = IW'(r_start - 17'd1);
            end
            t_SHIFT_WR: begin
                w_we    = 1'b1;
                w_waddr = IW'(r_start);
                w_wdata = r_rdata;
                n_start = r_start - 17'd1;
            end
            t_COMMIT: begin
                w_we      = 1'b1;
                w_wdata   = {r_prev_end[15:0], r_need[15:0]};
                n_live    = r_live + CW'(1);
                n_granted = 1'b1;
                n_address = r_pool_base + {13'd0, r_prev_end, 2'b00};
                if ({1'b0, r_hw} < (r_prev_end + r_need)) begin
                    n_hw = 16'(r_prev_end + r_need);
                end
            end
            t_DIV: begin
                w_dreq.start    = 1'b0;
            end
            default: begin
            end
        endcase
        if (n_state == t_DIV && r_state != t_DIV) begin
            w_dreq.start    = 1'b1;
            w_dreq.dividend = {7'd0, n_hw} * 23'd100;
            w_dreq.divisor  = r_pool_words;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= t_IDLE;
            r_live    <= '0;
            r_hw      <= '0;
        end else begin
            r_state   <= n_state;
            r_live    <= n_live;
            r_hw      <= n_hw;
        end
        r_idx      <= n_idx;
        r_need     <= n_need;
        r_prev_end <= n_prev_end;
        r_start    <= n_start;
        r_address  <= n_address;
        r_granted  <= n_granted;
        if (r_state == t_DIV && !w_drsp.busy) begin
            r_empty <= (r_pool_words == '0);
            r_util  <= (r_pool_words == '0) ? 7'd0 : w_drsp.quot;
        end
    end

    // Result word.
    assign o_in_stall            = (r_state != t_IDLE);
    assign o_out_valid           = (r_state == t_DONE);
    assign o_address             = r_address;
    assign o_granted             = r_granted;
    assign o_utilisation_percent = r_util;
    assign o_pool_empty_error    = r_empty;
    assign o_entry_count         = 8'(r_live);

endmodule

/* dv/first_fit_pool_allocator_checker.sv */
module first_fit_pool_allocator_checker
    import ffpa_pkg::*;
#(
    parameter int MAX_ENTRIES = MaxEntriesDef
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    input  logic        i_in_stall,
    input  logic        i_func,
    input  logic [17:0] i_size_bytes,
    input  logic        i_out_valid,
    input  logic        i_out_stall,
    input  logic [31:0] i_address,
    input  logic        i_granted,
    input  logic [6:0]  i_utilisation_percent,
    input  logic        i_pool_empty_error,
    input  logic [7:0]  i_entry_count,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:2]  paddr,
    input  logic [31:0] pwdata,
    input  logic        pready,
    output int          o_fail_count,
    output int          o_pending,
    output int          o_words_checked,
    output int          o_grants,
    output int          o_full_refusals
);

    typedef struct packed {
        logic [31:0] address;
        logic        granted;
        logic [6:0]  utilisation_percent;
        logic        pool_empty_error;
        logic [7:0]  entry_count;
    } t_alloc_result;

    // Mirror of the allocator's registers and extent table.
    logic [31:0]   pool_base;
    logic [15:0]   pool_words;
    logic [15:0]   ext_start [MAX_ENTRIES];
    logic [15:0]   ext_len [MAX_ENTRIES];
    int            live;
    longint        peak_words;
    t_alloc_result expected_q [$];

    function automatic longint ext_end(input int i);
        return longint'(ext_start[i]) + longint'(ext_len[i]);
    endfunction

    // A gap that runs past the pool top is cut back; it may go negative.
    function automatic longint clamp_to_pool(input longint s, input longint l);
        longint top;
        top = longint'(pool_words);
        if (top < s + l) l = top - s;
        return l;
    endfunction

    // First-fit placement of one request, updating the mirrored table.
    function automatic t_alloc_result place_request(input logic f, input logic [17:0] sz);
        t_alloc_result r;
        longint        need;
        longint        gstart;
        longint        glen;
        longint        util;
        int            idx;
        r = '0;
        if (f == FUNC_CLEAR) begin
            live = 0;
            peak_words = 0;
        end else if (live < MAX_ENTRIES) begin
            need = (longint'(sz) + 3) >>> 2;
            idx = 0;
            gstart = 0;
            if (live == 0) begin
                glen = clamp_to_pool(0, longint'(pool_words));
            end else begin
                forever begin
                    gstart = (idx == 0) ? 0 : ext_end(idx - 1);
                    glen = clamp_to_pool(gstart, longint'(ext_start[idx]) - gstart);
                    if (glen >= need) break;
                    idx++;
                    if (idx >= live) begin
                        gstart = ext_end(idx - 1);
                        glen = clamp_to_pool(gstart, longint'(pool_words) - gstart);
                        break;
                    end
                end
            end
            if (need <= glen) begin
                for (int k = live; k > idx; k--) begin
                    ext_start[k] = ext_start[k - 1];
                    ext_len[k] = ext_len[k - 1];
                end
                ext_start[idx] = gstart[15:0];
                ext_len[idx] = need[15:0];
                live++;
                r.granted = 1'b1;
                r.address = pool_base + 32'(gstart << 2);
                if (peak_words < gstart + need) peak_words = (gstart + need) & 64'hFFFF;
            end
        end
        if (pool_words == 0) begin
            r.pool_empty_error = 1'b1;
        end else begin
            util = (peak_words * 100) / longint'(pool_words);
            if (util > UtilCap) util = UtilCap;
            r.utilisation_percent = util[6:0];
        end
        r.entry_count = live[7:0];
        return r;
    endfunction

    // Watch the configuration port and both word channels.
    always @(posedge i_clk) begin
        t_alloc_result want;
        if (!i_rst_n) begin
            pool_base = '0;
            pool_words = '0;
            live = 0;
            peak_words = 0;
            expected_q.delete();
            o_fail_count = 0;
            o_words_checked = 0;
            o_grants = 0;
            o_full_refusals = 0;
        end else begin
            if (psel && penable && pwrite && pready) begin
                if (paddr == REG_POOL_BASE) pool_base = pwdata;
                else pool_words = pwdata[15:0];
            end
            if (i_in_valid && !i_in_stall) begin
                if (i_func == FUNC_ALLOC && live >= MAX_ENTRIES) o_full_refusals++;
                expected_q.push_back(place_request(i_func, i_size_bytes));
            end
            if (i_out_valid && !i_out_stall) begin
                o_words_checked++;
                if (expected_q.size() == 0) begin
                    $error("result word with no request outstanding");
                    o_fail_count++;
                end else begin
                    want = expected_q.pop_front();
                    if (want.granted) o_grants++;
                    if (i_address !== want.address) begin
                        $error("address: expected %h, got %h", want.address, i_address);
                        o_fail_count++;
                    end
                    if (i_granted !== want.granted) begin
                        $error("granted: expected %0d, got %0d", want.granted, i_granted);
                        o_fail_count++;
                    end
                    if (i_utilisation_percent !== want.utilisation_percent) begin
                        $error("utilisation_percent: expected %0d, got %0d",
                               want.utilisation_percent, i_utilisation_percent);
                        o_fail_count++;
                    end
                    if (i_pool_empty_error !== want.pool_empty_error) begin
                        $error("pool_empty_error: expected %0d, got %0d",
                               want.pool_empty_error, i_pool_empty_error);
                        o_fail_count++;
                    end
                    if (i_entry_count !== want.entry_count) begin
                        $error("entry_count: expected %0d, got %0d",
                               want.entry_count, i_entry_count);
                        o_fail_count++;
                    end
                end
            end
        end
        o_pending = expected_q.size();
    end

endmodule

/* dv/first_fit_pool_allocator_test.sv */
module first_fit_pool_allocator_test;
    import ffpa_pkg::*;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_stall;
    logic        i_func;
    logic [17:0] i_size_bytes;
    logic        o_out_valid;
    logic        i_out_stall;
    logic [31:0] o_address;
    logic        o_granted;
    logic [6:0]  o_utilisation_percent;
    logic        o_pool_empty_error;
    logic [7:0]  o_entry_count;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:2]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    int fail_count;
    int pending;
    int words_checked;
    int grants;
    int full_refusals;
    bit calm;
    bit hold_request;

    first_fit_pool_allocator i_dut (.*);

    first_fit_pool_allocator_checker i_checker (
        .i_clk, .i_rst_n, .i_in_valid,
        .i_in_stall(o_in_stall), .i_func, .i_size_bytes,
        .i_out_valid(o_out_valid), .i_out_stall,
        .i_address(o_address), .i_granted(o_granted),
        .i_utilisation_percent(o_utilisation_percent),
        .i_pool_empty_error(o_pool_empty_error), .i_entry_count(o_entry_count),
        .psel, .penable, .pwrite, .paddr, .pwdata, .pready,
        .o_fail_count(fail_count), .o_pending(pending),
        .o_words_checked(words_checked), .o_grants(grants),
        .o_full_refusals(full_refusals)
    );

    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    initial begin
        #60_000_000;
        $display("first_fit_pool_allocator_test: FAIL");
        $finish;
    end

    // Result side: a random hold-off on each waiting word, once a long one.
    initial begin
        int w;
        i_out_stall = 1'b0;
        @(posedge i_clk);
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            w = calm ? 0 : $urandom_range(0, 5);
            if (hold_request) begin
                hold_request = 1'b0;
                w = 400;
            end
            if (w > 0) begin
                i_out_stall <= 1'b1;
                do @(posedge i_clk); while (!o_out_valid);
                repeat (w - 1) @(posedge i_clk);
            end
            i_out_stall <= 1'b0;
            do @(posedge i_clk); while (!o_out_valid);
        end
    end

    // Offer one request word and wait until it is taken.
    task automatic issue(input logic f, input logic [17:0] sz);
        int gap;
        gap = calm ? 0 : $urandom_range(0, 5);
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_func <= f;
        i_size_bytes <= sz;
        do @(posedge i_clk); while (o_in_stall);
    endtask

    // Drain outstanding results, then write one register.
    task automatic write_reg(input logic idx, input logic [31:0] value);
        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (40) @(posedge i_clk);
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= idx;
        pwdata <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
    endtask

    // Mostly small sizes so the table fills; some span the whole field.
    function automatic logic [17:0] pick_size(input logic [15:0] words);
        int roll;
        roll = $urandom_range(0, 99);
        if (roll < 10) return 18'($urandom_range(0, 262143));
        if (roll < 15) return '0;
        if (roll < 25) return 18'($urandom_range(0, 4 * int'(words) + 8));
        return 18'($urandom_range(0, 16));
    endfunction

    initial begin
        logic [31:0] bases [8];
        logic [15:0] sizes [8];
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_func = FUNC_ALLOC;
        i_size_bytes = '0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = REG_POOL_BASE;
        pwdata = '0;
        calm = 1'b0;
        hold_request = 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero pool, then a full-size pool placed at the top of memory.
        issue(FUNC_ALLOC, 18'd0);
        issue(FUNC_ALLOC, 18'd5);
        issue(FUNC_CLEAR, 18'h3FFFF);
        write_reg(REG_POOL_BASE, 32'hFFFF_FFFC);
        write_reg(REG_POOL_WORDS, 32'h0000_FFFF);
        issue(FUNC_ALLOC, 18'h3FFFF);
        issue(FUNC_ALLOC, 18'd262140);
        issue(FUNC_ALLOC, 18'd0);
        issue(FUNC_ALLOC, 18'd4);
        issue(FUNC_CLEAR, 18'd0);
        issue(FUNC_ALLOC, 18'd1);
        issue(FUNC_ALLOC, 18'd3);
        issue(FUNC_ALLOC, 18'd8);
        // Shrink the pool under live extents so the gaps turn negative.
        write_reg(REG_POOL_WORDS, 32'd2);
        issue(FUNC_ALLOC, 18'd0);
        issue(FUNC_ALLOC, 18'd4);
        issue(FUNC_CLEAR, 18'd0);
        // Fill the table with zero-length extents, then overflow it.
        calm = 1'b1;
        for (int i = 0; i < 130; i++) issue(FUNC_ALLOC, 18'd0);
        calm = 1'b0;
        hold_request = 1'b1;
        for (int i = 0; i < 6; i++) issue(FUNC_ALLOC, 18'($urandom_range(0, 7)));
        issue(FUNC_CLEAR, 18'd0);

        // Random phases over a spread of pool settings, clears kept rare.
        bases = '{32'h0, 32'hFFFF_FFF0, $urandom, $urandom, $urandom,
                  32'hFFFF_FFFF, $urandom, 32'h0};
        sizes = '{16'd0, 16'hFFFF, 16'd200, 16'd40, 16'($urandom_range(1, 65535)),
                  16'd1, 16'($urandom), 16'd1000};
        for (int p = 0; p < 8; p++) begin
            write_reg(REG_POOL_BASE, bases[p]);
            write_reg(REG_POOL_WORDS, {16'h0, sizes[p]});
            calm = (p == 2);
            for (int i = 0; i < 125; i++) begin
                if ($urandom_range(0, 99) < 3) issue(FUNC_CLEAR, 18'($urandom));
                else issue(FUNC_ALLOC, pick_size(sizes[p]));
            end
        end
        calm = 1'b0;

        i_in_valid <= 1'b0;
        @(negedge i_clk);
        while (pending != 0) @(negedge i_clk);
        repeat (600) @(posedge i_clk);
        $display("Covered %0d result words across 11 pool settings, %0d grants,",
                 words_checked, grants);
        $display("and %0d requests refused on a full table.", full_refusals);
        if (fail_count == 0 && pending == 0) begin
            $display("first_fit_pool_allocator_test: PASS");
        end else begin
            $display("first_fit_pool_allocator_test: FAIL");
        end
        $finish;
    end

endmodule
